/* hdl/assert_macros.svh */
// Assertion shorthands used by the point projector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/fpp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_pkg
// Widths, register indexes and helpers of the point projector.
// ----------------------------------------------------------------------------
package fpp_pkg;

  localparam int COORD_W = 21;
  localparam int COEF_W  = 13;
  localparam int ROW_W   = 3 * COEF_W;
  localparam int CTR_W   = 12;
  localparam int PIX_W   = 14;
  localparam int IDX_W   = 3;
  localparam int Q_ONE   = 2048;
  localparam int Q_SHIFT = 11;

  localparam logic [IDX_W-1:0] REG_ROW0     = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROW1     = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROW2     = 3'd2;
  localparam logic [IDX_W-1:0] REG_CENTRE_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_CENTRE_Y = 3'd4;

  localparam logic [ROW_W-1:0] ROW0_RESET = 39'd2048;
  localparam logic [ROW_W-1:0] ROW1_RESET = 39'd16777216;
  localparam logic [ROW_W-1:0] ROW2_RESET = 39'd137438953472;
  localparam logic [CTR_W-1:0] CTR_RESET  = 12'd256;

  localparam logic [2:0] PIX_CENTER = 3'd0;
  localparam logic [2:0] PIX_UP     = 3'd1;
  localparam logic [2:0] PIX_DOWN   = 3'd2;
  localparam logic [2:0] PIX_RIGHT  = 3'd3;
  localparam logic [2:0] PIX_LEFT   = 3'd4;

  localparam logic signed [PIX_W-1:0] PIX_MIN = 14'sh2000;
  localparam logic signed [PIX_W-1:0] PIX_MAX = 14'sh1FFF;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic [ROW_W-1:0]          row_t;
  typedef logic [CTR_W-1:0]          ctr_t;
  typedef logic signed [PIX_W-1:0]   pix_t;
  typedef logic signed [16:0]        screen_t;
  typedef logic signed [17:0]        wide_pix_t;

  function automatic coef_t row_coef(input row_t row, input logic [1:0] k);
    coef_t c;
    unique case (k)
      2'd0:    c = row[COEF_W-1:0];
      2'd1:    c = row[2*COEF_W-1:COEF_W];
      default: c = row[3*COEF_W-1:2*COEF_W];
    endcase
    return c;
  endfunction

  function automatic logic signed [1:0] pix_dx(input logic [2:0] k);
    logic signed [1:0] d;
    unique case (k)
      PIX_RIGHT: d = 2'sd1;
      PIX_LEFT:  d = -2'sd1;
      default:   d = 2'sd0;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] pix_dy(input logic [2:0] k);
    logic signed [1:0] d;
    unique case (k)
      PIX_UP:   d = 2'sd1;
      PIX_DOWN: d = -2'sd1;
      default:  d = 2'sd0;
    endcase
    return d;
  endfunction

  function automatic pix_t sat_pix(input wide_pix_t v);
    pix_t r;
    priority if (v < 18'(PIX_MIN)) begin
      r = PIX_MIN;
    end else if (v > 18'(PIX_MAX)) begin
      r = PIX_MAX;
    end else begin
      r = v[PIX_W-1:0];
    end
    return r;
  endfunction

endpackage

/* hdl/fixed_point_point_projection.sv */
`timescale 1ns / 1ps
// A visible point yields five pixel words on the one-word-per-cycle output
// port, stalling the input meanwhile; a culled point yields one word, so
// culled points flow one per cycle while out_stall stays low.
// Five multiply/add stages, an expander stage and an output register.
// Synchronous active-high reset clears valid bits and restores the registers.
// ----------------------------------------------------------------------------
// fixed_point_point_projection
// Rotates and perspective-scales a 3D point in Q11 and emits a plus-shaped
// footprint of five saturated screen pixels, or one culled word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fixed_point_point_projection (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fpp_pkg::IDX_W-1:0]     cfg_index,
  input  logic [fpp_pkg::ROW_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [fpp_pkg::COORD_W-1:0] point_x,
  input  logic signed [fpp_pkg::COORD_W-1:0] point_y,
  input  logic signed [fpp_pkg::COORD_W-1:0] point_z,
  input  logic                          list_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [fpp_pkg::PIX_W-1:0] pixel_x,
  output logic signed [fpp_pkg::PIX_W-1:0] pixel_y,
  output logic                          visible,
  output logic                          run_last,
  output logic                          list_done
);
  import fpp_pkg::*;

  row_t matrix_row0, matrix_row1, matrix_row2;
  ctr_t centre_x, centre_y;

  logic ld1, ld2, ld3, ld4, ld5, ld_e, ld_o;
  logic e_take, e_fin;

  logic                s1_valid, s1_end;
  coord_t              s1_x, s1_y, s1_z;
  logic signed [33:0]  s1_d0, s1_d1, s1_d2;

  logic                s2_valid, s2_end, s2_vis;
  coord_t              s2_x, s2_y, s2_z;
  logic [CTR_W-1:0]    s2_scale;
  logic signed [35:0]  dsum;

  logic                s3_valid, s3_end, s3_vis;
  logic signed [22:0]  s3_x, s3_y, s3_z;
  logic signed [33:0]  m_x, m_y, m_z;

  logic                s4_valid, s4_end, s4_vis;
  logic signed [35:0]  s4_a0, s4_a1, s4_a2, s4_b0, s4_b1, s4_b2;

  logic                s5_valid, s5_end, s5_vis;
  screen_t             s5_x, s5_y;
  logic signed [37:0]  sum_a, sum_b;

  logic                e_valid, e_end, e_vis;
  screen_t             e_x, e_y;
  logic [2:0]          e_k;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_row0 <= ROW0_RESET;
      matrix_row1 <= ROW1_RESET;
      matrix_row2 <= ROW2_RESET;
      centre_x    <= CTR_RESET;
      centre_y    <= CTR_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW0:     matrix_row0 <= cfg_data;
        REG_ROW1:     matrix_row1 <= cfg_data;
        REG_ROW2:     matrix_row2 <= cfg_data;
        REG_CENTRE_X: centre_x    <= cfg_data[CTR_W-1:0];
        REG_CENTRE_Y: centre_y    <= cfg_data[CTR_W-1:0];
        default: ;
      endcase
    end
  end

  assign ld_o   = !out_valid || !out_stall;
  assign e_take = e_valid && ld_o;
  assign e_fin  = e_take && (!e_vis || e_k == PIX_LEFT);
  assign ld_e   = !e_valid || e_fin;
  assign ld5    = !s5_valid || ld_e;
  assign ld4    = !s4_valid || ld5;
  assign ld3    = !s3_valid || ld4;
  assign ld2    = !s2_valid || ld3;
  assign ld1    = !s1_valid || ld2;
  assign in_stall = !ld1;

  // depth row products
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ld1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_x   <= point_x;
      s1_y   <= point_y;
      s1_z   <= point_z;
      s1_end <= list_end;
      s1_d0  <= 34'(row_coef(matrix_row2, 2'd0)) * 34'(point_x);
      s1_d1  <= 34'(row_coef(matrix_row2, 2'd1)) * 34'(point_y);
      s1_d2  <= 34'(row_coef(matrix_row2, 2'd2)) * 34'(point_z);
    end
  end

  // depth, cull test and scale
  assign dsum = 36'(s1_d0) + 36'(s1_d1) + 36'(s1_d2);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ld2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_x     <= s1_x;
      s2_y     <= s1_y;
      s2_z     <= s1_z;
      s2_end   <= s1_end;
      s2_vis   <= dsum >= 36'(Q_ONE);
      s2_scale <= CTR_W'(Q_ONE) + {2'b00, dsum[34:25]};
    end
  end

  // perspective scaling
  assign m_x = 34'(s2_x) * 34'($signed({1'b0, s2_scale}));
  assign m_y = 34'(s2_y) * 34'($signed({1'b0, s2_scale}));
  assign m_z = 34'(s2_z) * 34'($signed({1'b0, s2_scale}));

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (ld3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_x   <= m_x[33:Q_SHIFT];
      s3_y   <= m_y[33:Q_SHIFT];
      s3_z   <= m_z[33:Q_SHIFT];
      s3_end <= s2_end;
      s3_vis <= s2_vis;
    end
  end

  // screen row products
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (ld4) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      s4_a0  <= 36'(row_coef(matrix_row0, 2'd0)) * 36'(s3_x);
      s4_a1  <= 36'(row_coef(matrix_row0, 2'd1)) * 36'(s3_y);
      s4_a2  <= 36'(row_coef(matrix_row0, 2'd2)) * 36'(s3_z);
      s4_b0  <= 36'(row_coef(matrix_row1, 2'd0)) * 36'(s3_x);
      s4_b1  <= 36'(row_coef(matrix_row1, 2'd1)) * 36'(s3_y);
      s4_b2  <= 36'(row_coef(matrix_row1, 2'd2)) * 36'(s3_z);
      s4_end <= s3_end;
      s4_vis <= s3_vis;
    end
  end

  // sum, shift and add centre
  assign sum_a = 38'(s4_a0) + 38'(s4_a1) + 38'(s4_a2);
  assign sum_b = 38'(s4_b0) + 38'(s4_b1) + 38'(s4_b2);

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (ld5) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld5) begin
      s5_x   <= 17'($signed(sum_a[37:2*Q_SHIFT])) + 17'($signed({1'b0, centre_x}));
      s5_y   <= 17'($signed(sum_b[37:2*Q_SHIFT])) + 17'($signed({1'b0, centre_y}));
      s5_end <= s4_end;
      s5_vis <= s4_vis;
    end
  end

  // footprint expander: hold the point, advance the pixel count
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (ld_e) begin
      e_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_e) begin
      e_x   <= s5_x;
      e_y   <= s5_y;
      e_end <= s5_end;
      e_vis <= s5_vis;
      e_k   <= PIX_CENTER;
    end else if (e_take) begin
      e_k   <= e_k + 3'd1;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld_o) begin
      out_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_o) begin
      if (e_vis) begin
        pixel_x <= sat_pix(18'(e_x) + 18'(pix_dx(e_k)));
        pixel_y <= sat_pix(18'(e_y) + 18'(pix_dy(e_k)));
      end else begin
        pixel_x <= '0;
        pixel_y <= '0;
      end
      visible   <= e_vis;
      run_last  <= !e_vis || e_k == PIX_LEFT;
      list_done <= (!e_vis || e_k == PIX_LEFT) && e_end;
    end
  end

  `ASSERT_NOW(a_cull_last, out_valid && !visible, run_last, "culled word not last")
  `ASSERT_NOW(a_done_last, out_valid && list_done, run_last, "list_done off last word")
  `ASSERT_NOW(a_k_range, e_valid, e_k <= PIX_LEFT, "pixel count out of range")
  `ASSERT_NOW(a_stall_full, in_stall, s1_valid, "input stalled with empty stage")
  `ASSERT_NEXT(a_hold_point, e_take && !e_fin, e_valid, "point dropped mid-footprint")

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams 3D points through the point projector and checks every pixel word
// against an in-bench fixed-point projection. View registers are reloaded
// between phases while the pipeline is empty. Gaps and back-pressure are
// randomized on both ports.
// ----------------------------------------------------------------------------
module testbench;
  import fpp_pkg::*;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } point_t;

  typedef struct packed {
    pix_t px;
    pix_t py;
    logic vis;
    logic last;
    logic done;
  } pixel_word_t;

  localparam int     CYCLE_LIMIT = 400000;
  localparam coord_t COORD_LO    = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t COORD_HI    = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coef_t  COEF_LO     = {1'b1, {(COEF_W-1){1'b0}}};
  localparam coef_t  COEF_HI     = {1'b0, {(COEF_W-1){1'b1}}};
  localparam row_t   ROW_ONES    = {ROW_W{1'b1}};

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_valid = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  row_t             cfg_data  = '0;
  logic             in_valid  = 1'b0;
  coord_t           point_x   = '0;
  coord_t           point_y   = '0;
  coord_t           point_z   = '0;
  logic             list_end  = 1'b0;
  logic             out_stall = 1'b0;
  logic             cfg_ready;
  logic             in_stall;
  logic             out_valid;
  pix_t             pixel_x;
  pix_t             pixel_y;
  logic             visible;
  logic             run_last;
  logic             list_done;

  row_t rot_row0  = ROW0_RESET;
  row_t rot_row1  = ROW1_RESET;
  row_t depth_row = ROW2_RESET;
  ctr_t ctr_x     = CTR_RESET;
  ctr_t ctr_y     = CTR_RESET;

  point_t      points_q[$];
  pixel_word_t pending_pixels[$];
  point_t      on_port;
  int          mismatches = 0;
  int          tx_gap     = 0;
  int          rx_gap     = 0;
  int          cycles     = 0;
  bit          no_idle    = 1'b0;
  bit          z_ahead    = 1'b1;

  fixed_point_point_projection DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .list_end  (list_end),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .visible   (visible),
    .run_last  (run_last),
    .list_done (list_done)
  );

  always #6 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic longint row_dot(input row_t r, input longint a, input longint b,
                                     input longint c);
    coef_t c0, c1, c2;
    c0 = r[COEF_W-1:0];
    c1 = r[2*COEF_W-1:COEF_W];
    c2 = r[3*COEF_W-1:2*COEF_W];
    return c0 * a + c1 * b + c2 * c;
  endfunction

  function automatic pix_t clip_pix(input longint v);
    if (v < PIX_MIN) return PIX_MIN;
    if (v > PIX_MAX) return PIX_MAX;
    return pix_t'(v);
  endfunction

  function automatic void apply_reg(input logic [IDX_W-1:0] idx, input row_t data);
    case (idx)
      REG_ROW0:     rot_row0 = data;
      REG_ROW1:     rot_row1 = data;
      REG_ROW2:     depth_row = data;
      REG_CENTRE_X: ctr_x = data[CTR_W-1:0];
      REG_CENTRE_Y: ctr_y = data[CTR_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic project_point(input point_t p);
    longint      px, py, pz, depth, scale, sx, sy, cx, cy, dx, dy;
    pixel_word_t w;
    px = p.x;
    py = p.y;
    pz = p.z;
    cx = ctr_x;
    cy = ctr_y;
    depth = row_dot(depth_row, px, py, pz) >>> Q_SHIFT;
    if (depth <= 0) begin
      w = '{px: '0, py: '0, vis: 1'b0, last: 1'b1, done: p.last};
      pending_pixels.push_back(w);
    end else begin
      scale = Q_ONE + (depth >>> (Q_SHIFT + 3));
      px = (px * scale) >>> Q_SHIFT;
      py = (py * scale) >>> Q_SHIFT;
      pz = (pz * scale) >>> Q_SHIFT;
      sx = (row_dot(rot_row0, px, py, pz) >>> (2 * Q_SHIFT)) + cx;
      sy = (row_dot(rot_row1, px, py, pz) >>> (2 * Q_SHIFT)) + cy;
      for (int k = PIX_CENTER; k <= PIX_LEFT; k++) begin
        dx = (k == PIX_RIGHT) ? 1 : (k == PIX_LEFT) ? -1 : 0;
        dy = (k == PIX_UP) ? 1 : (k == PIX_DOWN) ? -1 : 0;
        w.px   = clip_pix(sx + dx);
        w.py   = clip_pix(sy + dy);
        w.vis  = 1'b1;
        w.last = (k == PIX_LEFT);
        w.done = (k == PIX_LEFT) ? p.last : 1'b0;
        pending_pixels.push_back(w);
      end
    end
  endtask

  task automatic check_pixel();
    pixel_word_t want;
    if (pending_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected pixel word: x=%0d y=%0d vis=%0b last=%0b done=%0b",
                 pixel_x, pixel_y, visible, run_last, list_done);
    end else begin
      want = pending_pixels.pop_front();
      if (pixel_x !== want.px || pixel_y !== want.py || visible !== want.vis ||
          run_last !== want.last || list_done !== want.done) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel mismatch: expected x=%0d y=%0d vis=%0b last=%0b done=%0b, %s",
                   want.px, want.py, want.vis, want.last, want.done,
                   $sformatf("got x=%0d y=%0d vis=%0b last=%0b done=%0b",
                             pixel_x, pixel_y, visible, run_last, list_done));
      end
    end
  endtask

  // point driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      if (in_valid && !in_stall) project_point(on_port);
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap   <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (points_q.size() > 0) begin
          on_port  = points_q.pop_front();
          point_x  <= on_port.x;
          point_y  <= on_port.y;
          point_z  <= on_port.z;
          list_end <= on_port.last;
          in_valid <= 1'b1;
          tx_gap   <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // pixel monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_gap    <= 0;
    end else begin
      if (out_valid && !out_stall) check_pixel();
      if (rx_gap > 0) begin
        out_stall <= 1'b1;
        rx_gap    <= rx_gap - 1;
      end else begin
        out_stall <= 1'b0;
        rx_gap    <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0:       return COORD_LO;
      1:       return COORD_HI;
      2, 3:    return coord_t'(int'($urandom_range(0, 64)) - 32);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic row_t pack_row(input coef_t c0, input coef_t c1, input coef_t c2);
    return {c2, c1, c0};
  endfunction

  function automatic coef_t near_unit();
    return coef_t'(int'($urandom_range(0, 4096)) - 2048);
  endfunction

  task automatic add_point(input coord_t x, input coord_t y, input coord_t z,
                           input logic last);
    point_t p;
    p = '{x: x, y: y, z: z, last: last};
    points_q.push_back(p);
  endtask

  task automatic add_random(input int n);
    point_t p;
    for (int i = 0; i < n; i++) begin
      p.x = rand_coord();
      p.y = rand_coord();
      p.z = rand_coord();
      // favor points in front of the viewer
      if (z_ahead && p.z < 0 && $urandom_range(0, 3) != 0) p.z = -p.z;
      p.last = ($urandom_range(0, 3) == 0);
      points_q.push_back(p);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (points_q.size() != 0 || in_valid || pending_pixels.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input row_t data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, data);
  endtask

  task automatic set_view(input row_t r0, input row_t r1, input row_t r2,
                          input row_t cx, input row_t cy);
    write_reg(REG_ROW0, r0);
    write_reg(REG_ROW1, r1);
    write_reg(REG_ROW2, r2);
    write_reg(REG_CENTRE_X, cx);
    write_reg(REG_CENTRE_Y, cy);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset view: identity rotation, centre at 256
    @(negedge clk);
    add_point(0, 0, 0, 1'b0);
    add_point(0, 0, 1, 1'b0);
    add_point(COORD_HI, COORD_HI, COORD_HI, 1'b1);
    add_point(COORD_LO, COORD_LO, COORD_HI, 1'b0);
    add_point(COORD_HI, COORD_LO, 1, 1'b1);
    add_point(0, 0, -1, 1'b1);
    add_point(COORD_LO, COORD_HI, COORD_LO, 1'b0);
    add_point(-1, -1, -1, 1'b0);
    add_point(1, -1, 16384, 1'b0);
    add_point(-1, 1, 16383, 1'b1);
    add_random(40);
    wait_idle();

    // flat rows, centre at the corners, no idling
    set_view('0, '0, ROW2_RESET, row_t'(4095), '0);
    no_idle = 1'b1;
    @(negedge clk);
    add_point(0, 0, 5, 1'b1);
    add_point(COORD_HI, COORD_HI, COORD_HI, 1'b0);
    add_random(30);
    wait_idle();
    no_idle = 1'b0;

    // every coefficient -1; centre data carries bits above the register width
    set_view(ROW_ONES, ROW_ONES, ROW_ONES, ROW_ONES, ROW_ONES);
    z_ahead = 1'b0;
    @(negedge clk);
    add_point(COORD_LO, COORD_LO, COORD_LO, 1'b1);
    add_random(40);
    wait_idle();

    // coefficient extremes
    set_view(pack_row(COEF_LO, COEF_HI, COEF_LO), pack_row(COEF_HI, COEF_LO, COEF_HI),
             pack_row(COEF_LO, COEF_LO, COEF_LO), '0, row_t'(4095));
    @(negedge clk);
    add_point(COORD_LO, COORD_LO, COORD_LO, 1'b0);
    add_point(COORD_LO, COORD_HI, COORD_LO, 1'b1);
    add_random(40);
    wait_idle();

    // random registers; writes past the last index must be dropped
    set_view(row_t'({$urandom, $urandom}), row_t'({$urandom, $urandom}),
             row_t'({$urandom, $urandom}), row_t'({$urandom, $urandom}),
             row_t'({$urandom, $urandom}));
    for (int k = REG_CENTRE_Y + 1; k < 2 ** IDX_W; k++)
      write_reg(IDX_W'(k), row_t'({$urandom, $urandom}));
    @(negedge clk);
    add_random(50);
    wait_idle();

    // rotation-like rows with a positive depth axis
    set_view(pack_row(near_unit(), near_unit(), near_unit()),
             pack_row(near_unit(), near_unit(), near_unit()),
             pack_row(near_unit() >>> 3, near_unit() >>> 3, coef_t'($urandom_range(1024, 2048))),
             row_t'($urandom_range(0, 4095)), row_t'($urandom_range(0, 4095)));
    z_ahead = 1'b1;
    @(negedge clk);
    add_random(50);
    wait_idle();

    // back to the reset view
    set_view(ROW0_RESET, ROW1_RESET, ROW2_RESET, CTR_RESET, CTR_RESET);
    @(negedge clk);
    add_random(70);
    wait_idle();

    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
